// ===== rtl/core/sdbf_pkg.sv =====
// Shared types, constants and helper functions for the sample stream
// double-buffer feeder. No dependencies.
`timescale 1ns / 1ps

package sdbf_pkg;

  // Geometry of the per-stream rings in voice memory.
  localparam int STREAMS   = 8;
  localparam int HALF_SIZE = 2048;
  localparam int RING_BASE = 36896;

  // Field widths fixed by the item layout.
  localparam int STREAM_W = 3;
  localparam int SRC_W    = 24;
  localparam int ADDR_W   = 21;
  localparam int REM_W    = SRC_W + 1;
  localparam int HALF_W   = $clog2(HALF_SIZE);
  localparam int SIDX_W   = (STREAMS > 1) ? $clog2(STREAMS) : 1;

  // Signed width that holds the playback offset from any ring base.
  localparam int RING_END = RING_BASE + STREAMS * 2 * HALF_SIZE;
  localparam int END_W    = $clog2(RING_END + 1);
  localparam int OFF_W    = ((END_W > ADDR_W) ? END_W : ADDR_W) + 1;

  // Stream bus widths.
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 64;

  // Lowest remaining count; subtraction saturates here.
  localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRIME = 3'd1,
    PH_KEYON = 3'd2,
    PH_PLAY  = 3'd3,
    PH_TAIL  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  localparam logic [1:0] VC_NONE       = 2'd0;
  localparam logic [1:0] VC_SET_REPEAT = 2'd1;
  localparam logic [1:0] VC_KEY_ON     = 2'd2;

  localparam logic [1:0] MK_NONE      = 2'd0;
  localparam logic [1:0] MK_HEAD_TAIL = 2'd1;
  localparam logic [1:0] MK_LOOP      = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_RANGE   = 2'd2;

  localparam logic REQ_START = 1'b1;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_CALC = 1'b1
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } sdbf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
  } sdbf_stat_t;

  // Subtract one half from the remaining count, saturating at the low end.
  function automatic logic signed [REM_W-1:0] sub_half(input logic signed [REM_W-1:0] v);
    logic signed [REM_W:0] d;
    d = {v[REM_W-1], v} - (REM_W+1)'(HALF_SIZE);
    if (d[REM_W] != d[REM_W-1]) begin
      sub_half = REM_MIN;
    end else begin
      sub_half = d[REM_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/sample_stream_double_buffer_feeder_top.sv =====
// Top level of the sample stream double-buffer feeder: controller plus datapath.
// An item passes through the input register, the step logic and the result
// register before m_tvalid rises.
// A new item is not taken until the controller has finished the capture then
// step sequence of the last one, nor while the result register is full.
// Reset (rst, synchronous, active high) puts every stream idle with zero state.
`timescale 1ns / 1ps

module sample_stream_double_buffer_feeder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // stream[2:0], sample_start[26:3], sample_end[50:27], sample_valid[51],
  // loop_byte_is_one[52], envelope_zero[53], play_addr[74:54], zeros above
  input  logic [sdbf_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type[0]
  input  logic [sdbf_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // transferred[0], write_en[1], write_half[2], write_src[26:3],
  // voice_cmd[28:27], mark_kind[30:29], mark_len[54:31], error[56:55],
  // phase_out[59:57], zeros above
  output logic [sdbf_pkg::OUT_DATA_W-1:0] m_tdata
);
  import sdbf_pkg::*;

  sdbf_cmd_t  cmd;
  sdbf_stat_t stat;

  // Sequencing of the handshake and the step.
  sdbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Per-stream state and step logic.
  sdbf_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== rtl/core/sdbf_ctrl.sv =====
// Controller state machine of the feeder: input handshake and sequencing.
// Depends on sdbf_pkg.
`timescale 1ns / 1ps

module sdbf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  sdbf_pkg::sdbf_stat_t stat,
  output sdbf_pkg::sdbf_cmd_t  cmd
);
  import sdbf_pkg::*;

  ctl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take an item only when the result register will be free for it.
  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      CS_IDLE: begin
        s_tready = !stat.out_full;
        if (s_tvalid && !stat.out_full) begin
          cmd.capture = 1'b1;
          state_next  = CS_CALC;
        end
      end
      CS_CALC: begin
        cmd.execute = 1'b1;
        state_next  = CS_IDLE;
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sdbf_datapath.sv =====
// Datapath of the feeder: input register, per-stream state, step logic and
// the result register. Depends on sdbf_pkg.
`timescale 1ns / 1ps

module sdbf_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [sdbf_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [sdbf_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sdbf_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  sdbf_pkg::sdbf_cmd_t                cmd,
  output sdbf_pkg::sdbf_stat_t               stat
);
  import sdbf_pkg::*;

  localparam logic signed [OFF_W-1:0] OFF_HALF = OFF_W'(HALF_SIZE);
  localparam logic signed [OFF_W-1:0] OFF_SPAN = OFF_W'(2 * HALF_SIZE);
  localparam logic signed [REM_W-1:0] REM_HALF = REM_W'(HALF_SIZE);
  localparam logic [SRC_W-1:0]        SRC_HALF = SRC_W'(HALF_SIZE);

  // Captured input item.
  logic                req_q;
  logic [STREAM_W-1:0] stream_q;
  logic [SRC_W-1:0]    start_q;
  logic [SRC_W-1:0]    end_q;
  logic                valid_q;
  logic                loop_q;
  logic                env_q;
  logic [ADDR_W-1:0]   paddr_q;

  // Per-stream state.
  phase_t                  phase_mem  [STREAMS];
  logic signed [REM_W-1:0] rem_mem    [STREAMS];
  logic [SRC_W-1:0]        ptr_mem    [STREAMS];
  logic                    marker_mem [STREAMS];

  // Result register.
  logic                out_valid;
  logic                transferred;
  logic                write_en;
  logic                write_half;
  logic [SRC_W-1:0]    write_src;
  logic [1:0]          voice_cmd;
  logic [1:0]          mark_kind;
  logic [SRC_W-1:0]    mark_len;
  logic [1:0]          error;
  phase_t              phase_out;

  // Step results.
  logic [SIDX_W-1:0]       sidx;
  logic                    in_range;
  phase_t                  ph, ph_play, phase_next;
  logic signed [REM_W-1:0] rem, rem_next, len;
  logic [SRC_W-1:0]        ptr, ptr_next;
  logic                    marker, marker_next;
  logic [OFF_W-1:0]        base;
  logic signed [OFF_W-1:0] off;
  logic                    do_write, wr_half;
  logic                    transferred_next, write_en_next, write_half_next;
  logic [SRC_W-1:0]        write_src_next, mark_len_next;
  logic [1:0]              voice_cmd_next, mark_kind_next, error_next;

  // Input register, loaded on each accepted transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q    <= s_tuser[0];
      stream_q <= s_tdata[2:0];
      start_q  <= s_tdata[26:3];
      end_q    <= s_tdata[50:27];
      valid_q  <= s_tdata[51];
      loop_q   <= s_tdata[52];
      env_q    <= s_tdata[53];
      paddr_q  <= s_tdata[74:54];
    end
  end

  assign sidx     = SIDX_W'(stream_q);
  assign in_range = (32'(stream_q) < STREAMS);
  assign ph       = phase_mem[sidx];
  assign rem      = rem_mem[sidx];
  assign ptr      = ptr_mem[sidx];
  assign marker   = marker_mem[sidx];
  assign len      = $signed({1'b0, end_q}) - $signed({1'b0, start_q});
  assign base     = OFF_W'(RING_BASE) + (OFF_W'(sidx) << (HALF_W + 1));
  assign off      = $signed({{(OFF_W-ADDR_W){1'b0}}, paddr_q}) - $signed(base);

  // One step of the addressed stream.
  always_comb begin
    phase_next       = ph;
    rem_next         = rem;
    ptr_next         = ptr;
    marker_next      = marker;
    ph_play          = ph;
    do_write         = 1'b0;
    wr_half          = 1'b0;
    transferred_next = 1'b0;
    write_en_next    = 1'b0;
    write_half_next  = 1'b0;
    write_src_next   = '0;
    voice_cmd_next   = VC_NONE;
    mark_kind_next   = MK_NONE;
    mark_len_next    = '0;
    error_next       = ERR_NONE;
    if (in_range) begin
      if (req_q == REQ_START) begin
        if (!valid_q) begin
          phase_next = PH_IDLE;
          error_next = ERR_INVALID;
        end else begin
          voice_cmd_next   = VC_SET_REPEAT;
          mark_kind_next   = MK_HEAD_TAIL;
          mark_len_next    = len[SRC_W-1:0];
          transferred_next = 1'b1;
          write_en_next    = 1'b1;
          write_src_next   = start_q;
          ptr_next         = start_q + SRC_HALF;
          rem_next         = sub_half(len);
          marker_next      = 1'b0;
          phase_next       = PH_PRIME;
        end
      end else begin
        case (ph)
          PH_PRIME: begin
            if (rem > 0) begin
              do_write = 1'b1;
              wr_half  = 1'b1;
              rem_next = sub_half(rem);
            end
            phase_next = PH_KEYON;
          end
          PH_KEYON: begin
            voice_cmd_next = VC_KEY_ON;
            marker_next    = 1'b1;
            phase_next     = (rem <= 0) ? PH_TAIL : PH_PLAY;
          end
          PH_PLAY: begin
            ph_play    = env_q ? PH_TAIL : PH_PLAY;
            phase_next = ph_play;
            if (off >= OFF_SPAN) begin
              error_next = ERR_RANGE;
            end else if (off[HALF_W] == marker) begin
              // Refill the half that playback has just left.
              do_write    = 1'b1;
              wr_half     = (off < OFF_HALF);
              marker_next = wr_half;
              if (rem <= REM_HALF) begin
                phase_next = phase_t'(ph_play + 3'd1);
              end else begin
                rem_next = sub_half(rem);
              end
            end
          end
          PH_TAIL: begin
            phase_next = PH_DONE;
          end
          default: begin
          end
        endcase
        // Half write and its loop mark use the state before the step.
        if (do_write) begin
          transferred_next = 1'b1;
          write_en_next    = 1'b1;
          write_half_next  = wr_half;
          write_src_next   = ptr;
          ptr_next         = ptr + SRC_HALF;
          if (wr_half && (rem > REM_HALF) && !loop_q) begin
            mark_kind_next = MK_LOOP;
          end
        end
      end
    end
  end

  // Per-stream state write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STREAMS; i++) begin
        phase_mem[i]  <= PH_IDLE;
        rem_mem[i]    <= '0;
        ptr_mem[i]    <= '0;
        marker_mem[i] <= 1'b0;
      end
    end else if (cmd.execute && in_range) begin
      phase_mem[sidx]  <= phase_next;
      rem_mem[sidx]    <= rem_next;
      ptr_mem[sidx]    <= ptr_next;
      marker_mem[sidx] <= marker_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      transferred <= transferred_next;
      write_en    <= write_en_next;
      write_half  <= write_half_next;
      write_src   <= write_src_next;
      voice_cmd   <= voice_cmd_next;
      mark_kind   <= mark_kind_next;
      mark_len    <= mark_len_next;
      error       <= error_next;
      phase_out   <= in_range ? phase_next : PH_IDLE;
    end
  end

  assign stat.out_full = out_valid && !m_tready;
  assign m_tvalid      = out_valid;
  assign m_tdata       = {4'b0, phase_out, error, mark_len, mark_kind, voice_cmd,
                          write_src, write_half, write_en, transferred};

endmodule

// ===== test/sample_stream_double_buffer_feeder_top_tb.sv =====
// Self-checking testbench for the sample stream double-buffer feeder top level.
// Holds its own per-stream predictor and checks every output transfer in order.
// Depends on sdbf_pkg and sample_stream_double_buffer_feeder_top.
`timescale 1ns / 1ps

module sample_stream_double_buffer_feeder_top_tb;
  import sdbf_pkg::*;

  localparam int  CLK_PERIOD  = 12;
  localparam int  MAX_REPORTS = 10;
  localparam time RUN_LIMIT   = 5ms;

  // One input item, as the block sees it.
  typedef struct packed {
    logic        req_type;
    logic [2:0]  stream;
    logic [23:0] sample_start;
    logic [23:0] sample_end;
    logic        sample_valid;
    logic        loop_byte_is_one;
    logic        envelope_zero;
    logic [20:0] play_addr;
  } feeder_req_t;

  // One result item: the commands issued by a step.
  typedef struct packed {
    logic        transferred;
    logic        write_en;
    logic        write_half;
    logic [23:0] write_src;
    logic [1:0]  voice_cmd;
    logic [1:0]  mark_kind;
    logic [23:0] mark_len;
    logic [1:0]  error;
    phase_t      phase_out;
  } feeder_cmd_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Per-stream shadow state of the feeder.
  phase_t                  stream_phase   [STREAMS];
  logic signed [REM_W-1:0] stream_left    [STREAMS];
  logic [SRC_W-1:0]        stream_src_ptr [STREAMS];
  logic                    stream_next_half[STREAMS];

  feeder_cmd_t pending_cmds[$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;

  sample_stream_double_buffer_feeder_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Remaining count minus one half, clamped at the lowest 25-bit value.
  function automatic logic signed [REM_W-1:0] drop_one_half(input logic signed [REM_W-1:0] v);
    int d;
    d = int'(v) - HALF_SIZE;
    if (d < -(1 << SRC_W)) begin
      d = -(1 << SRC_W);
    end
    return d[REM_W-1:0];
  endfunction

  // Copy of one half out of the source; a half 1 write may carry the loop mark.
  function automatic void issue_half_write(input int s, input logic half, input logic loop_one,
                                           inout feeder_cmd_t r);
    r.transferred = 1'b1;
    r.write_en    = 1'b1;
    r.write_half  = half;
    r.write_src   = stream_src_ptr[s];
    if (half && stream_left[s] > HALF_SIZE && !loop_one) begin
      r.mark_kind = MK_LOOP;
    end
    stream_src_ptr[s] = stream_src_ptr[s] + SRC_W'(HALF_SIZE);
  endfunction

  // Expected commands for one accepted item; advances the shadow state.
  function automatic feeder_cmd_t predict_feeder_cmds(input feeder_req_t it);
    feeder_cmd_t r;
    int          s;
    int          len;
    int          off;
    logic        off_half;
    r = '0;
    s = int'(it.stream);
    if (it.req_type == REQ_START) begin
      if (!it.sample_valid) begin
        stream_phase[s] = PH_IDLE;
        r.error = ERR_INVALID;
      end else begin
        len = int'({1'b0, it.sample_end}) - int'({1'b0, it.sample_start});
        r.voice_cmd   = VC_SET_REPEAT;
        r.mark_kind   = MK_HEAD_TAIL;
        r.mark_len    = len[SRC_W-1:0];
        r.transferred = 1'b1;
        r.write_en    = 1'b1;
        r.write_half  = 1'b0;
        r.write_src   = it.sample_start;
        stream_src_ptr[s]   = it.sample_start + SRC_W'(HALF_SIZE);
        stream_left[s]      = drop_one_half(len[REM_W-1:0]);
        stream_next_half[s] = 1'b0;
        stream_phase[s]     = PH_PRIME;
      end
    end else begin
      case (stream_phase[s])
        PH_PRIME: begin
          if (stream_left[s] > 0) begin
            issue_half_write(s, 1'b1, it.loop_byte_is_one, r);
            stream_left[s] = drop_one_half(stream_left[s]);
          end
          stream_phase[s] = PH_KEYON;
        end
        PH_KEYON: begin
          r.voice_cmd         = VC_KEY_ON;
          stream_next_half[s] = 1'b1;
          stream_phase[s]     = (stream_left[s] <= 0) ? PH_TAIL : PH_PLAY;
        end
        PH_PLAY: begin
          off = int'(it.play_addr) - (RING_BASE + s * 2 * HALF_SIZE);
          if (it.envelope_zero) begin
            stream_phase[s] = PH_TAIL;
          end
          if (off >= 2 * HALF_SIZE) begin
            r.error = ERR_RANGE;
          end else begin
            // Offsets below the ring take their half bit from two's complement.
            off_half = (off & HALF_SIZE) != 0;
            if (off_half == stream_next_half[s]) begin
              if (off < HALF_SIZE) begin
                issue_half_write(s, 1'b1, it.loop_byte_is_one, r);
                stream_next_half[s] = 1'b1;
              end else begin
                issue_half_write(s, 1'b0, it.loop_byte_is_one, r);
                stream_next_half[s] = 1'b0;
              end
              if (stream_left[s] <= HALF_SIZE) begin
                stream_phase[s] = phase_t'(stream_phase[s] + 3'd1);
              end else begin
                stream_left[s] = drop_one_half(stream_left[s]);
              end
            end
          end
        end
        PH_TAIL: begin
          stream_phase[s] = PH_DONE;
        end
        default: begin
        end
      endcase
    end
    r.phase_out = stream_phase[s];
    return r;
  endfunction

  // Offer one item, wait for its transfer, and queue the expected commands.
  task automatic send_feeder_req(input feeder_req_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.req_type;
    s_tdata  <= {5'b0, it.play_addr, it.envelope_zero, it.loop_byte_is_one, it.sample_valid,
                 it.sample_end, it.sample_start, it.stream};
    do begin
      @(posedge clk);
    end while (!s_tready);
    pending_cmds.push_back(predict_feeder_cmds(it));
  endtask

  task automatic send_item(input logic req, input int s, input logic [23:0] first,
                           input logic [23:0] last, input logic valid, input logic loop_one,
                           input logic env_zero, input logic [20:0] paddr);
    feeder_req_t it;
    it.req_type         = req;
    it.stream           = s[2:0];
    it.sample_start     = first;
    it.sample_end       = last;
    it.sample_valid     = valid;
    it.loop_byte_is_one = loop_one;
    it.envelope_zero    = env_zero;
    it.play_addr        = paddr;
    send_feeder_req(it);
  endtask

  // Playback address at a given offset into the ring of stream s.
  function automatic logic [20:0] ring_addr(input int s, input int off);
    return 21'(RING_BASE + s * 2 * HALF_SIZE + off);
  endfunction

  // Stop offering and wait until every queued result has been checked.
  task automatic wait_for_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Start checks: invalid entries, negative, huge and wrapping lengths.
  task automatic test_start_checks();
    send_item(1'b0, 0, 24'h0, 24'h0, 1'b0, 1'b0, 1'b0, 21'h0);
    send_item(1'b1, 7, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1, 1'b1, 21'h1FFFFF);
    send_item(1'b1, 1, 24'hFFFFFF, 24'h000000, 1'b1, 1'b0, 1'b0, 21'h0);
    send_item(1'b0, 1, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, ring_addr(1, 0));
    send_item(1'b0, 1, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, ring_addr(1, 0));
    send_item(1'b0, 1, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, ring_addr(1, 0));
    send_item(1'b0, 1, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, ring_addr(1, 0));
    // The source pointer wraps past the top of the 24-bit space here.
    send_item(1'b1, 3, 24'hFFF000, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 21'h0);
    send_item(1'b0, 3, 24'h0, 24'h0, 1'b1, 1'b1, 1'b0, 21'h0);
    send_item(1'b0, 3, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 21'h0);
    send_item(1'b1, 6, 24'h000000, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 21'h0);
  endtask

  // Walk one stream through prime, keyon, play refills, errors and tail.
  task automatic test_phase_walk();
    send_item(1'b1, 5, 24'h000100, 24'h000100 + 24'd6244, 1'b1, 1'b0, 1'b0, 21'h0);
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 21'h0);
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 21'h0);
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, ring_addr(5, 100));
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, ring_addr(5, 3000));
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 21'h0);
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 21'h1FFFFF);
    // Envelope reaches zero on the step of the last refill.
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b1, ring_addr(5, 10));
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, ring_addr(5, 10));
    send_item(1'b1, 5, 24'h000000, 24'h001000, 1'b1, 1'b1, 1'b0, 21'h0);
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 21'h0);
    send_item(1'b0, 5, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 21'h0);
  endtask

  // Mostly well-formed stream lifetimes over all slots, plus noise.
  task automatic send_random_items(input int count);
    feeder_req_t it;
    int          s;
    int          base;
    int          pick;
    int          len;
    repeat (count) begin
      s    = $urandom_range(STREAMS - 1);
      base = RING_BASE + s * 2 * HALF_SIZE;
      it   = '0;
      it.stream           = s[2:0];
      it.sample_valid     = 1'b1;
      it.loop_byte_is_one = 1'($urandom_range(1));
      it.envelope_zero    = ($urandom_range(99) < 4);
      it.sample_start     = 24'($urandom_range(24'hFFFFFF));
      it.sample_end       = 24'($urandom_range(24'hFFFFFF));
      it.play_addr        = 21'($urandom_range(21'h1FFFFF));
      if (stream_phase[s] inside {PH_IDLE, PH_DONE}) begin
        it.req_type = ($urandom_range(99) < 60);
      end else begin
        it.req_type = ($urandom_range(99) < 4);
      end
      if (it.req_type == REQ_START) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          it.sample_valid = 1'b0;
        end else if (pick < 80) begin
          len = $urandom_range(5 * HALF_SIZE + 500);
          it.sample_end = it.sample_start + 24'(len);
        end else if (pick < 90) begin
          len = $urandom_range(3 * HALF_SIZE);
          it.sample_end = it.sample_start - 24'(len);
        end
      end else if (stream_phase[s] == PH_PLAY) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          it.play_addr = 21'(base + (stream_next_half[s] ? HALF_SIZE : 0)
                             + $urandom_range(HALF_SIZE - 1));
        end else if (pick < 80) begin
          it.play_addr = 21'(base + (stream_next_half[s] ? 0 : HALF_SIZE)
                             + $urandom_range(HALF_SIZE - 1));
        end else if (pick < 87) begin
          it.play_addr = 21'($urandom_range(base - 1, 0));
        end else if (pick < 93) begin
          it.play_addr = 21'($urandom_range(21'h1FFFFF, base + 2 * HALF_SIZE));
        end
      end
      send_feeder_req(it);
    end
  endtask

  // Receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure_fill();
    wait_for_drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = 80;
    send_random_items(16);
    // Sender pauses here until every result is back.
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    wait_for_drain();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_random_items(count);
  endtask

  // Receiver ready: long hold-off when requested, random stalls otherwise.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready    <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  // Compare each output transfer with the oldest expectation.
  always @(posedge clk) begin
    feeder_cmd_t got;
    feeder_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.transferred = m_tdata[0];
      got.write_en    = m_tdata[1];
      got.write_half  = m_tdata[2];
      got.write_src   = m_tdata[26:3];
      got.voice_cmd   = m_tdata[28:27];
      got.mark_kind   = m_tdata[30:29];
      got.mark_len    = m_tdata[54:31];
      got.error       = m_tdata[56:55];
      got.phase_out   = phase_t'(m_tdata[59:57]);
      if (pending_cmds.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result transfer with none expected, data %0h", $time, m_tdata);
        end
      end else begin
        want = pending_cmds.pop_front();
        check_field("transferred", 24'(want.transferred), 24'(got.transferred));
        check_field("write_en", 24'(want.write_en), 24'(got.write_en));
        check_field("write_half", 24'(want.write_half), 24'(got.write_half));
        check_field("write_src", want.write_src, got.write_src);
        check_field("voice_cmd", 24'(want.voice_cmd), 24'(got.voice_cmd));
        check_field("mark_kind", 24'(want.mark_kind), 24'(got.mark_kind));
        check_field("mark_len", want.mark_len, got.mark_len);
        check_field("error", 24'(want.error), 24'(got.error));
        check_field("phase_out", 24'(want.phase_out), 24'(got.phase_out));
      end
    end
  end

  // Run limit.
  initial begin
    #(RUN_LIMIT);
    $display("FAIL sample_stream_double_buffer_feeder_top");
    $finish;
  end

  // Test sequence.
  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    for (int i = 0; i < STREAMS; i++) begin
      stream_phase[i]     = PH_IDLE;
      stream_left[i]      = '0;
      stream_src_ptr[i]   = '0;
      stream_next_half[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_start_checks();
    test_phase_walk();
    test_backpressure_fill();
    test_random_traffic(170, 0, 0);
    test_random_traffic(170, 45, 0);
    test_random_traffic(170, 0, 45);
    test_random_traffic(170, 8, 8);

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("PASS sample_stream_double_buffer_feeder_top");
    end else begin
      $display("FAIL sample_stream_double_buffer_feeder_top");
    end
    $finish;
  end

endmodule
